### rtl/smdr_pkg.sv
// ----------------------------------------------------------------------------
// Signed multiply-divide package
// Word width, counter width, beat layout and controller state encoding.
// ----------------------------------------------------------------------------
package smdr_pkg;

   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(WORD_BITS);
   localparam int REQ_BITS  = ((3 * WORD_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = ((2 * WORD_BITS + 7) / 8) * 8;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_FIX  = 5'b01000,
      ST_SIGN = 5'b10000
   } state_type;

endpackage

### rtl/signed_muldiv_with_remainder.sv
// ----------------------------------------------------------------------------
// Signed multiply-divide with remainder
// Computes a*b/c and its remainder on operand magnitudes, one bit a cycle.
// ----------------------------------------------------------------------------
// The divide of |b| by |c| runs first, then the shift-add pass over the bits of |a|.
// A new request is taken only in the idle state, after the last result has moved
// into the output register.
// A finished result waits in the output register while the next request runs.
// Reset is synchronous and clears the controller and the output valid flag.
module signed_muldiv_with_remainder
   import smdr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // Fields from bit 0 up: multiplicand, multiplier, divisor.
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // Fields from bit 0 up: quotient, remainder.
   output logic [RSP_BITS-1:0] rsp_tdata
);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   word_type              ua_ff, ua_in;
   word_type              ub_ff, ub_in;
   word_type              uc_ff, uc_in;
   word_type              rn_ff, rn_in;
   word_type              q_ff, q_in;
   word_type              r_ff, r_in;
   logic                  inc_ff, inc_in;
   logic                  rneg_ff, rneg_in;
   logic                  qneg_ff, qneg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              rsp_q_ff, rsp_q_in;
   word_type              rsp_r_ff, rsp_r_in;

   word_type              a_w, b_w, c_w;
   logic [WORD_BITS:0]    trial, trial_sub;
   logic                  trial_ge;
   logic [WORD_BITS:0]    r_sum, r_sub;
   logic                  r_ge;
   word_type              addend;
   logic                  req_beat, out_free;

   assign a_w = req_tdata[WORD_BITS-1:0];
   assign b_w = req_tdata[2*WORD_BITS-1:WORD_BITS];
   assign c_w = req_tdata[3*WORD_BITS-1:2*WORD_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_r_ff, rsp_q_ff});

   // Shared restoring step: a divide step while dividing, a doubling of the
   // partial quotient and remainder during the shift-add pass.
   assign trial     = {rn_ff, (state_ff == ST_DIV) ? ub_ff[WORD_BITS-1] : 1'b0};
   assign trial_sub = trial - {1'b0, uc_ff};
   assign trial_ge  = !trial_sub[WORD_BITS];

   assign r_sum  = {1'b0, r_ff} + {1'b0, rn_ff};
   assign r_sub  = r_sum - {1'b0, uc_ff};
   assign r_ge   = !r_sub[WORD_BITS];
   assign addend = ua_ff[0] ? ub_ff : '0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ua_in        = ua_ff;
      ub_in        = ub_ff;
      uc_in        = uc_ff;
      rn_in        = rn_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      inc_in       = inc_ff;
      rneg_in      = rneg_ff;
      qneg_in      = qneg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_q_in     = rsp_q_ff;
      rsp_r_in     = rsp_r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               ua_in    = a_w[WORD_BITS-1] ? word_type'(-a_w) : a_w;
               ub_in    = b_w[WORD_BITS-1] ? word_type'(-b_w) : b_w;
               if (c_w == '0) begin
                  uc_in = word_type'(1);
               end else begin
                  uc_in = c_w[WORD_BITS-1] ? word_type'(-c_w) : c_w;
               end
               rneg_in  = a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
               qneg_in  = a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1] ^ c_w[WORD_BITS-1];
               rn_in    = '0;
               q_in     = '0;
               r_in     = '0;
               inc_in   = 1'b0;
               cnt_in   = CNT_BITS'(WORD_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rn_in = trial_ge ? trial_sub[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            ub_in = {ub_ff[WORD_BITS-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_BITS'(WORD_BITS - 1);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            q_in   = q_ff + addend + word_type'(inc_ff);
            inc_in = ua_ff[0] && r_ge;
            if (ua_ff[0]) begin
               r_in = r_ge ? r_sub[WORD_BITS-1:0] : r_sum[WORD_BITS-1:0];
            end
            ua_in  = {1'b0, ua_ff[WORD_BITS-1:1]};
            rn_in  = trial_ge ? trial_sub[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            ub_in  = {ub_ff[WORD_BITS-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            q_in     = q_ff + word_type'(inc_ff);
            inc_in   = 1'b0;
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_q_in     = qneg_ff ? word_type'(-q_ff) : q_ff;
               rsp_r_in     = rneg_ff ? word_type'(-r_ff) : r_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      uc_ff    <= uc_in;
      rn_ff    <= rn_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      inc_ff   <= inc_in;
      rneg_ff  <= rneg_in;
      qneg_ff  <= qneg_in;
      rsp_q_ff <= rsp_q_in;
      rsp_r_ff <= rsp_r_in;
   end

endmodule

### rtl/smdr_checker.sv
// ----------------------------------------------------------------------------
// Signed multiply-divide port checker
// Watches the stream ports of the block over time.
// ----------------------------------------------------------------------------
module smdr_checker
   import smdr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [REQ_BITS-1:0] req_tdata,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // A result beat that is not taken stays offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The block is busy right after taking a request.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("request taken while busy");

   // The block stays busy while the divide and the shift-add pass run.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |-> ##60 !req_tready)
      else $error("request finished too early");

   // A request beat that waits keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> $stable(req_tdata))
      else $error("request payload changed while waiting");

endmodule

bind signed_muldiv_with_remainder smdr_checker u_smdr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
